@@ sv/rsqt_pkg.sv @@
// Package for the region sum query table: field widths, register codes,
// controller states and the command and status structs.
// No dependencies.
package rsqt_pkg;

	localparam int IDX_BITS     = 6;
	localparam int ELEM_BITS    = 16;
	localparam int PREFIX_BITS  = 22;
	localparam int SUM_BITS     = 29;
	localparam int CFG_BITS     = 7;
	localparam int CFG_IDX_BITS = 2;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

	localparam logic [CFG_IDX_BITS-1:0] REG_ROWS = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_COLS = 2'd1;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic rx_ready;
		logic take;
		logic issue;
		logic publish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic query;
		logic err;
		logic empty;
		logic last_row;
		logic rsp_busy;
	} dp_stat_t;

endpackage

@@ sv/rsqt_if.sv @@
// Channel interfaces of the region sum query table: request, response and
// configuration write. Depends on rsqt_pkg.
interface rsqt_req_if import rsqt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [IDX_BITS-1:0]  row_a;
	logic [IDX_BITS-1:0]  col_a;
	logic [IDX_BITS-1:0]  row_b;
	logic [IDX_BITS-1:0]  col_b;
	logic signed [ELEM_BITS-1:0] value;

	modport source (output valid, func, row_a, col_a, row_b, col_b, value, input ready);
	modport sink (input valid, func, row_a, col_a, row_b, col_b, value, output ready);
	modport monitor (input valid, ready, func, row_a, col_a, row_b, col_b, value);
endinterface

interface rsqt_rsp_if import rsqt_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SUM_BITS-1:0] region_sum;
	logic                       status;

	modport source (output valid, region_sum, status, input ready);
	modport sink (input valid, region_sum, status, output ready);
endinterface

interface rsqt_cfg_if import rsqt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [CFG_BITS-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ sv/rsqt_ctrl.sv @@
// Controller of the region sum query table: request acceptance, row sweep
// sequencing and result hand-off. Depends on rsqt_pkg.
module rsqt_ctrl import rsqt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (stat.query && !stat.err && !stat.empty) begin
						state_d = ST_RUN;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_RUN: begin
				if (stat.last_row) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!stat.rsp_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.rx_ready = (state_q == ST_IDLE);
		cmd.take     = (state_q == ST_IDLE) && req_valid;
		cmd.issue    = (state_q == ST_RUN);
		cmd.publish  = (state_q == ST_DONE) && !stat.rsp_busy;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q != ST_IDLE)
		else $error("accepted request did not leave idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> $past(state_q) == ST_RUN)
		else $error("drain entered without a row sweep");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> state_q == ST_IDLE)
		else $error("publish did not return to idle");

endmodule

@@ sv/rsqt_dp.sv @@
// Datapath of the region sum query table: configuration registers, range
// checks, load accumulator, prefix memory, row sum and response register.
// Depends on rsqt_pkg and rsqt_if.
module rsqt_dp import rsqt_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic       clk,
	input  logic       arst_n,
	rsqt_req_if.sink   req,
	rsqt_rsp_if.source rsp,
	rsqt_cfg_if.sink   cfg,
	input  ctrl_cmd_t  cmd,
	output dp_stat_t   stat
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EXT   = SUM_BITS - PREFIX_BITS;
	localparam int PEXT  = PREFIX_BITS - ELEM_BITS;

	logic [CFG_BITS-1:0]    rows_q, cols_q;
	logic [PREFIX_BITS-1:0] acc_q, acc_d;
	logic [PREFIX_BITS-1:0] prefix_mem_q [DEPTH];
	logic [PREFIX_BITS-1:0] pb_s1, pa_s1;
	logic                   rd_valid_s1;
	logic [IDX_BITS-1:0]    row_q, rb_q, ca_q, cb_q;
	logic [SUM_BITS-1:0]    sum_q, sum_add, sum_sub;
	logic                   status_q;
	logic                   rsp_valid_q, rsp_status_q;
	logic [SUM_BITS-1:0]    rsp_sum_q;
	logic [31:0]            wr_addr, rd_addr_b, rd_addr_a;
	logic                   ra_ok, ca_ok, rb_ok, cb_ok;
	logic [IDX_BITS-1:0]    ca_prev;

	assign req.ready = cmd.rx_ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_RESET;
			cols_q <= CFG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ROWS: rows_q <= cfg.data;
				REG_COLS: cols_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign ra_ok = ({1'b0, req.row_a} < rows_q) && (32'(req.row_a) < 32'(MAX_ROWS));
	assign rb_ok = ({1'b0, req.row_b} < rows_q) && (32'(req.row_b) < 32'(MAX_ROWS));
	assign ca_ok = ({1'b0, req.col_a} < cols_q) && (32'(req.col_a) < 32'(MAX_COLS));
	assign cb_ok = ({1'b0, req.col_b} < cols_q) && (32'(req.col_b) < 32'(MAX_COLS));

	always_comb begin
		stat.query    = (req.func == FUNC_QUERY);
		stat.err      = (req.func == FUNC_QUERY) ? !(ra_ok && rb_ok && ca_ok && cb_ok)
		                                         : !(ra_ok && ca_ok);
		stat.empty    = req.row_a > req.row_b;
		stat.last_row = (row_q == rb_q);
		stat.rsp_busy = rsp_valid_q && !rsp.ready;
	end

	assign acc_d = (req.col_a == '0) ? {{PEXT{req.value[ELEM_BITS-1]}}, req.value}
	                                 : acc_q + {{PEXT{req.value[ELEM_BITS-1]}}, req.value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.take && req.func == FUNC_LOAD && !stat.err) begin
			acc_q <= acc_d;
		end
	end

	assign wr_addr   = 32'(req.row_a) * 32'(MAX_COLS) + 32'(req.col_a);
	assign ca_prev   = ca_q - IDX_BITS'(1);
	assign rd_addr_b = 32'(row_q) * 32'(MAX_COLS) + 32'(cb_q);
	assign rd_addr_a = 32'(row_q) * 32'(MAX_COLS) + 32'(ca_prev);

	always_ff @(posedge clk) begin
		if (cmd.take && req.func == FUNC_LOAD && !stat.err) begin
			prefix_mem_q[wr_addr[AW-1:0]] <= acc_d;
		end
		if (cmd.issue) begin
			pb_s1 <= prefix_mem_q[rd_addr_b[AW-1:0]];
			pa_s1 <= prefix_mem_q[rd_addr_a[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.issue;
		end
	end

	assign sum_add = {{EXT{pb_s1[PREFIX_BITS-1]}}, pb_s1};
	assign sum_sub = (ca_q != '0) ? {{EXT{pa_s1[PREFIX_BITS-1]}}, pa_s1} : '0;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			row_q    <= req.row_a;
			rb_q     <= req.row_b;
			ca_q     <= req.col_a;
			cb_q     <= req.col_b;
			sum_q    <= '0;
			status_q <= stat.err;
		end else begin
			if (cmd.issue) begin
				row_q <= row_q + IDX_BITS'(1);
			end
			if (rd_valid_s1) begin
				sum_q <= sum_q + sum_add - sum_sub;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			rsp_sum_q    <= sum_q;
			rsp_status_q <= status_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.region_sum = rsp_sum_q;
	assign rsp.status     = rsp_status_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> !(rsp_valid_q && !rsp.ready))
		else $error("result published over a waiting response");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> row_q <= rb_q)
		else $error("row sweep ran past the last row");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q |-> rsp_sum_q == '0)
		else $error("error response with nonzero sum");

endmodule

@@ sv/region_sum_query_table.sv @@
// Top level of the region sum query table: joins controller and datapath.
// Depends on rsqt_pkg, rsqt_if, rsqt_ctrl and rsqt_dp.
//
// The block holds a matrix as running sums along each row, in a prefix memory
// of MAX_ROWS x MAX_COLS entries with one write and two read ports. A load
// writes one element. A query for rows row_a to row_b sweeps those rows,
// reading the two prefix entries of one row per cycle from the memory; a
// query that fails its range check or has an empty row span skips the sweep.
// One request is handled at a time; a new request is taken while a finished
// result still waits in the response register. The memory is not cleared
// after reset, and a query must only touch entries that loads have written.
module region_sum_query_table import rsqt_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input logic        clk,
	input logic        arst_n,
	rsqt_req_if.sink   req,
	rsqt_rsp_if.source rsp,
	rsqt_cfg_if.sink   cfg
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	rsqt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	rsqt_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule

@@ tb/sv/rsqt_checker.sv @@
// Checker for the region sum query table: watches the request, response and
// register write channels, predicts every result and compares it field by field.
// Depends on rsqt_pkg and rsqt_if.
module rsqt_checker import rsqt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rsqt_req_if.monitor req,
	rsqt_rsp_if         rsp,
	rsqt_cfg_if         cfg,
	output int unsigned outstanding,
	output int unsigned fail_count,
	output int unsigned results_checked,
	output int unsigned range_flags
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [SUM_BITS-1:0] region_sum;
		logic                       status;
	} sum_result_t;

	sum_result_t expected_sums[$];

	logic [PREFIX_BITS-1:0] prefix_mem [DEF_MAX_ROWS*DEF_MAX_COLS];
	logic [PREFIX_BITS-1:0] run_acc;
	logic [CFG_BITS-1:0]    rows_reg;
	logic [CFG_BITS-1:0]    cols_reg;

	function automatic sum_result_t table_step(input logic fn,
			input logic [IDX_BITS-1:0] ra, input logic [IDX_BITS-1:0] ca,
			input logic [IDX_BITS-1:0] rb, input logic [IDX_BITS-1:0] cb,
			input logic signed [ELEM_BITS-1:0] v);
		sum_result_t res;
		int nr;
		int nc;
		logic signed [PREFIX_BITS-1:0] elem;
		logic signed [PREFIX_BITS-1:0] hi;
		logic signed [PREFIX_BITS-1:0] lo;
		logic signed [SUM_BITS-1:0] term;
		logic signed [SUM_BITS-1:0] total;
		res.region_sum = '0;
		res.status = 1'b0;
		nr = (int'(rows_reg) > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows_reg);
		nc = (int'(cols_reg) > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols_reg);
		if (fn == FUNC_LOAD) begin
			if (int'(ra) >= nr || int'(ca) >= nc) begin
				res.status = 1'b1;
			end else begin
				elem = v;
				run_acc = (ca == '0) ? elem : run_acc + elem;
				prefix_mem[int'(ra) * DEF_MAX_COLS + int'(ca)] = run_acc;
			end
		end else begin
			if (int'(ra) >= nr || int'(rb) >= nr || int'(ca) >= nc || int'(cb) >= nc) begin
				res.status = 1'b1;
			end else if (ra <= rb) begin
				total = '0;
				for (int r = int'(ra); r <= int'(rb); r++) begin
					hi = prefix_mem[r * DEF_MAX_COLS + int'(cb)];
					term = hi;
					total = total + term;
					if (ca != '0) begin
						lo = prefix_mem[r * DEF_MAX_COLS + int'(ca) - 1];
						term = lo;
						total = total - term;
					end
				end
				res.region_sum = total;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sum_result_t want;
		if (!arst_n) begin
			expected_sums.delete();
			run_acc = '0;
			rows_reg = CFG_RESET;
			cols_reg = CFG_RESET;
			fail_count = 0;
			results_checked = 0;
			range_flags = 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_sums.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: sum %0d status %0b with nothing outstanding",
							rsp.region_sum, rsp.status);
				end else begin
					want = expected_sums.pop_front();
					results_checked++;
					if (want.status)
						range_flags++;
					if (rsp.region_sum !== want.region_sum || rsp.status !== want.status) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result %0d mismatch: expected sum %0d status %0b, got sum %0d status %0b",
								results_checked, want.region_sum, want.status,
								rsp.region_sum, rsp.status);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ROWS: rows_reg = cfg.data;
					REG_COLS: cols_reg = cfg.data;
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				expected_sums.insert(expected_sums.size(), table_step(req.func, req.row_a,
					req.col_a, req.row_b, req.col_b, req.value));
			outstanding <= expected_sums.size();
		end
	end

endmodule

@@ tb/sv/region_sum_query_table_tb.sv @@
// Top of the region sum query table testbench: clock, reset, stimulus and verdict.
// Loads rows and asks rectangle sums under several table sizes; rsqt_checker does the
// checking. Depends on rsqt_pkg, rsqt_if, rsqt_checker and region_sum_query_table.
module region_sum_query_table_tb;
	import rsqt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
	localparam logic signed [ELEM_BITS-1:0] ELEM_MAX = {1'b0, {(ELEM_BITS-1){1'b1}}};
	localparam logic signed [ELEM_BITS-1:0] ELEM_MIN = {1'b1, {(ELEM_BITS-1){1'b0}}};
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int END_PAUSE = 100;

	logic clk = 1'b0;
	logic arst_n;

	rsqt_req_if req();
	rsqt_rsp_if rsp();
	rsqt_cfg_if cfg();

	int unsigned outstanding;
	int unsigned fail_count;
	int unsigned results_checked;
	int unsigned range_flags;

	int nr = DEF_MAX_ROWS;
	int nc = DEF_MAX_COLS;
	int burst_left = 0;
	int items_sent = 0;
	int loads_sent = 0;
	int queries_sent = 0;
	int settings_run = 0;
	int idle_cycles = 0;
	bit written [DEF_MAX_ROWS][DEF_MAX_COLS];

	region_sum_query_table u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	rsqt_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.rsp             (rsp),
		.cfg             (cfg),
		.outstanding     (outstanding),
		.fail_count      (fail_count),
		.results_checked (results_checked),
		.range_flags     (range_flags)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [IDX_BITS-1:0] pick_idx(input int n);
		if (n == 0)
			return IDX_BITS'($urandom);
		return IDX_BITS'($urandom_range(0, n - 1));
	endfunction

	function automatic logic signed [ELEM_BITS-1:0] elem_value();
		case ($urandom_range(0, 7))
			0: return ELEM_MIN;
			1: return ELEM_MAX;
			2: return ELEM_BITS'($urandom_range(0, 6) - 3);
			default: return ELEM_BITS'($urandom);
		endcase
	endfunction

	function automatic bit query_safe(input logic [IDX_BITS-1:0] ra, input logic [IDX_BITS-1:0] ca,
			input logic [IDX_BITS-1:0] rb, input logic [IDX_BITS-1:0] cb);
		if (int'(ra) >= nr || int'(rb) >= nr || int'(ca) >= nc || int'(cb) >= nc || ra > rb)
			return 1'b1;
		for (int r = int'(ra); r <= int'(rb); r++) begin
			if (!written[r][cb])
				return 1'b0;
			if (ca != '0 && !written[r][ca-1])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic wait_idle();
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic send_item(input logic fn, input logic [IDX_BITS-1:0] ra,
			input logic [IDX_BITS-1:0] ca, input logic [IDX_BITS-1:0] rb,
			input logic [IDX_BITS-1:0] cb, input logic signed [ELEM_BITS-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
		end
		burst_left--;
		req.valid <= 1'b1;
		req.func  <= fn;
		req.row_a <= ra;
		req.col_a <= ca;
		req.row_b <= rb;
		req.col_b <= cb;
		req.value <= v;
		do @(posedge clk); while (!req.ready);
		items_sent++;
		if (fn == FUNC_LOAD) begin
			loads_sent++;
			if (int'(ra) < nr && int'(ca) < nc)
				written[ra][ca] = 1'b1;
		end else begin
			queries_sent++;
		end
	endtask

	task automatic load_elem(input logic [IDX_BITS-1:0] r, input logic [IDX_BITS-1:0] c,
			input logic signed [ELEM_BITS-1:0] v);
		send_item(FUNC_LOAD, r, c, IDX_BITS'($urandom), IDX_BITS'($urandom), v);
	endtask

	task automatic ask_sum(input logic [IDX_BITS-1:0] ra, input logic [IDX_BITS-1:0] ca,
			input logic [IDX_BITS-1:0] rb, input logic [IDX_BITS-1:0] cb);
		send_item(FUNC_QUERY, ra, ca, rb, cb, ELEM_BITS'($urandom));
	endtask

	task automatic send_row(input logic [IDX_BITS-1:0] r, input int len);
		for (int c = 0; c < len; c++)
			load_elem(r, IDX_BITS'(c), elem_value());
	endtask

	task automatic send_random_query();
		logic [IDX_BITS-1:0] ra, ca, rb, cb;
		int kind, span;
		bit safe;
		safe = 1'b0;
		for (int tries = 0; tries < 40 && !safe; tries++) begin
			kind = $urandom_range(0, 99);
			ra = pick_idx(nr);
			ca = pick_idx(nc);
			cb = pick_idx(nc);
			span = int'(ra) + $urandom_range(0, 3);
			rb = ($urandom_range(0, 1) == 0 && span < nr) ? IDX_BITS'(span) : pick_idx(nr);
			if (kind < 95) begin
				if (kind >= 80 && kind < 85) begin
					if (ra < rb)
						{ra, rb} = {rb, ra};
				end else if (ra > rb) begin
					{ra, rb} = {rb, ra};
				end
				if (kind >= 70 && kind < 80) begin
					if (ca < cb)
						{ca, cb} = {cb, ca};
				end else if (ca > cb) begin
					{ca, cb} = {cb, ca};
				end
				if (kind >= 85) begin
					case ($urandom_range(0, 3))
						0: if (nr < DEF_MAX_ROWS) ra = IDX_BITS'($urandom_range(nr, DEF_MAX_ROWS - 1));
						1: if (nr < DEF_MAX_ROWS) rb = IDX_BITS'($urandom_range(nr, DEF_MAX_ROWS - 1));
						2: if (nc < DEF_MAX_COLS) ca = IDX_BITS'($urandom_range(nc, DEF_MAX_COLS - 1));
						default: if (nc < DEF_MAX_COLS) cb = IDX_BITS'($urandom_range(nc, DEF_MAX_COLS - 1));
					endcase
				end
			end else begin
				ra = IDX_BITS'($urandom);
				ca = IDX_BITS'($urandom);
				rb = IDX_BITS'($urandom);
				cb = IDX_BITS'($urandom);
			end
			safe = query_safe(ra, ca, rb, cb);
		end
		if (!safe) begin
			ra = IDX_BITS'(DEF_MAX_ROWS - 1);
			rb = '0;
		end
		ask_sum(ra, ca, rb, cb);
	endtask

	task automatic program_table(input logic [CFG_BITS-1:0] rows_val,
			input logic [CFG_BITS-1:0] cols_val);
		logic [CFG_IDX_BITS-1:0] idx [3];
		logic [CFG_BITS-1:0] dat [3];
		int n;
		idx = '{REG_ROWS, REG_COLS, REG_SPARE};
		dat = '{rows_val, cols_val, CFG_BITS'($urandom)};
		n = (settings_run % 3 == 1) ? 3 : 2;
		wait_idle();
		for (int i = 0; i < n; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[i];
			cfg.data  <= dat[i];
			do @(posedge clk); while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
		nr = (int'(rows_val) > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(rows_val);
		nc = (int'(cols_val) > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(cols_val);
		settings_run++;
	endtask

	task automatic run_phase(input logic [CFG_BITS-1:0] rows_val,
			input logic [CFG_BITS-1:0] cols_val, input int budget);
		int start, kind, len, c;
		logic [IDX_BITS-1:0] r;
		logic signed [ELEM_BITS-1:0] v;
		program_table(rows_val, cols_val);
		start = items_sent;
		for (int fr = 0; fr < nr && (fr + 1) * nc <= 64; fr++)
			send_row(IDX_BITS'(fr), nc);
		while (items_sent - start < budget) begin
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				if (nc == 0)
					len = $urandom_range(1, 4);
				else
					len = ($urandom_range(0, 1) == 0) ? nc : $urandom_range(1, nc);
				send_row(pick_idx(nr), len);
			end else if (kind < 82) begin
				repeat ($urandom_range(1, 6)) send_random_query();
			end else if (kind < 92) begin
				load_elem(IDX_BITS'($urandom), IDX_BITS'($urandom), elem_value());
			end else if (kind < 99 || nc < 2 || nr == 0) begin
				r = pick_idx(nr);
				c = pick_idx(nc);
				repeat ($urandom_range(2, 5)) load_elem(r, IDX_BITS'(c), elem_value());
			end else begin
				// drive the running sum past its width
				r = pick_idx(nr);
				c = $urandom_range(1, nc - 1);
				v = ($urandom_range(0, 1) == 0) ? ELEM_MAX : ELEM_MIN;
				repeat ($urandom_range(66, 72)) load_elem(r, IDX_BITS'(c), v);
			end
		end
		req.valid <= 1'b0;
	endtask

	initial begin
		logic [15:0] pat;
		int age;
		rsp.ready <= 1'b0;
		pat = '1;
		age = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (age == 0) begin
				case ($urandom_range(0, 4))
					0, 1: pat = '1;
					2: pat = 16'($urandom) | 16'h0001;
					3: pat = 16'h0001;
					default: pat = 16'h00FF;
				endcase
				age = $urandom_range(30, 400);
			end
			age--;
			rsp.ready <= pat[15];
			pat = {pat[14:0], pat[15]};
		end
	end

	initial begin
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
			WATCHDOG_LIMIT, outstanding);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		req.valid <= 1'b0;
		req.func  <= FUNC_LOAD;
		req.row_a <= '0;
		req.col_a <= '0;
		req.row_b <= '0;
		req.col_b <= '0;
		req.value <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_ROWS;
		cfg.data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-size table straight out of reset
		load_elem(0, 0, ELEM_MIN);
		load_elem(0, 1, ELEM_MAX);
		load_elem(0, 2, -1);
		load_elem(0, 3, 1);
		load_elem(1, 0, ELEM_MAX);
		load_elem(1, 1, ELEM_MAX);
		load_elem(1, 2, ELEM_MIN);
		load_elem(1, 3, 0);
		load_elem(63, 62, ELEM_MIN);
		load_elem(63, 63, ELEM_MAX);
		ask_sum(0, 0, 1, 3);
		ask_sum(0, 1, 1, 2);
		ask_sum(0, 3, 1, 1);
		ask_sum(1, 0, 0, 3);
		ask_sum(63, 63, 63, 63);
		ask_sum(0, 0, 0, 0);
		req.valid <= 1'b0;

		// small table: indexes just past the edge
		program_table(7'd2, 7'd4);
		load_elem(2, 0, 7);
		load_elem(0, 4, 9);
		ask_sum(0, 0, 2, 0);
		ask_sum(0, 0, 1, 4);
		ask_sum(2, 0, 1, 3);
		ask_sum(0, 0, 1, 3);
		load_elem(1, 3, 5);
		ask_sum(1, 3, 1, 3);
		req.valid <= 1'b0;

		run_phase(7'd64, 7'd64, 300);
		run_phase(7'd1, 7'd1, 60);
		run_phase(7'd64, 7'd1, 120);
		run_phase(7'd1, 7'd64, 120);
		run_phase(7'd0, 7'd9, 30);
		run_phase(7'd12, 7'd0, 30);
		run_phase(7'd5, 7'd7, 150);
		run_phase(7'd127, 7'd100, 200);
		run_phase(7'd3, 7'd127, 100);
		run_phase(7'd16, 7'd16, 200);
		run_phase(7'd8, 7'd3, 100);

		wait_idle();
		repeat (END_PAUSE) @(posedge clk);
		$display("%0d requests sent (%0d loads, %0d rectangle queries) across %0d register settings",
			items_sent, loads_sent, queries_sent, settings_run + 1);
		$display("%0d results checked, %0d of them flagged out of range", results_checked, range_flags);
		if (fail_count == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
